FILE: design/priority_task_table_assert.svh
// Assertion macros for the priority task table.
// Needs nothing else; included by the top level, which checks its own logic.
`ifndef PRIORITY_TASK_TABLE_ASSERT_SVH
`define PRIORITY_TASK_TABLE_ASSERT_SVH

// same-cycle implication
`define PTT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ptt_pkg.sv
// Shared types, codes and sizes of the priority task table.
// No dependencies; imported by every module of the block.
package ptt_pkg;

   localparam int TABLE_SIZE   = 16;
   localparam int IDX_W        = $clog2(TABLE_SIZE);
   localparam int CNT_W        = $clog2(TABLE_SIZE + 1);
   localparam int ID_W         = 8;
   localparam int WORKER_W     = 8;
   localparam int PRIO_W       = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PRIO_W-1:0] MIN_PRIORITY = PRIO_W'(1);
   localparam logic [PRIO_W-1:0] MAX_PRIORITY = PRIO_W'(5);

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_ASSIGN   = 2'd1,
      CMD_COMPLETE = 2'd2,
      CMD_CANCEL   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      RS_OK        = 3'd0,
      RS_BAD_PRIO  = 3'd1,
      RS_FULL      = 3'd2,
      RS_NOT_FOUND = 3'd3,
      RS_BAD_STATE = 3'd4,
      RS_NONE      = 3'd5
   } rsp_status_type;

   typedef enum logic [1:0] {
      ST_PENDING   = 2'd0,
      ST_RUNNING   = 2'd1,
      ST_COMPLETED = 2'd2,
      ST_CANCELLED = 2'd3
   } entry_state_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [PRIO_W-1:0]   priority_req;
      logic [ID_W-1:0]     task_id;
      logic [WORKER_W-1:0] worker;
   } req_type;

   typedef struct packed {
      rsp_status_type      status;
      logic [ID_W-1:0]     result_id;
      logic                cancel_notify;
      logic [WORKER_W-1:0] notify_worker;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      cmd_type             cmd;
      logic                prio_ok;
      logic                id_zero;
      logic [PRIO_W-1:0]   priority_req;
      logic [ID_W-1:0]     task_id;
      logic [WORKER_W-1:0] worker;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [PRIO_W-1:0]   prio;
      entry_state_type     state;
      logic [WORKER_W-1:0] owner;
   } entry_type;

endpackage

FILE: design/ptt_front.sv
// Front end of the priority task table: accepts command words and classifies them.
// Depends on ptt_pkg; feeds the command queue.
module ptt_front import ptt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output op_type  q_push_data
);

   logic   stage_valid_ff, stage_valid_in;
   op_type stage_ff, stage_in;
   logic   accept;

   assign q_push      = stage_valid_ff && !q_full;
   assign q_push_data = stage_ff;
   assign req_ready   = !stage_valid_ff || !q_full;
   assign accept      = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_in       = stage_ff;
      if (q_push) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in        = 1'b1;
         stage_in.cmd          = req_data.cmd;
         stage_in.prio_ok      = (req_data.priority_req >= MIN_PRIORITY) &&
                                 (req_data.priority_req <= MAX_PRIORITY);
         stage_in.id_zero      = (req_data.task_id == '0);
         stage_in.priority_req = req_data.priority_req;
         stage_in.task_id      = req_data.task_id;
         stage_in.worker       = req_data.worker;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

endmodule

FILE: design/ptt_queue.sv
// Short command queue between the front and back of the priority task table.
// Depends on ptt_pkg for the queue depth and the command type.
module ptt_queue import ptt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  op_type           push_data,
   input  logic             pop,
   output op_type           pop_data,
   output queue_status_type status
);

   op_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LVL_W-1:0] level_ff, level_in;

   assign status.full  = (level_ff == QUEUE_LVL_W'(QUEUE_DEPTH));
   assign status.empty = (level_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   level_in = level_ff + QUEUE_LVL_W'(1);
         2'b01:   level_in = level_ff - QUEUE_LVL_W'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/ptt_back.sv
// Back end of the priority task table: holds the task entries, runs each command
// and registers its result word. Depends on ptt_pkg; pops the command queue.
module ptt_back import ptt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  op_type           q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_SCAN
   } state_type;

   entry_type entry_mem [TABLE_SIZE];

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [IDX_W-1:0]  best_slot_ff, best_slot_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   entry_type         rd_data_ff;
   logic [IDX_W-1:0]  rd_slot_ff;

   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   logic              better;
   logic              last;
   logic [PRIO_W-1:0] nb_prio;
   logic [IDX_W-1:0]  nb_slot;
   logic              nb_found;

   function automatic rsp_type make_rsp(rsp_status_type st, logic [ID_W-1:0] rid,
                                        logic note, logic [WORKER_W-1:0] wkr);
      rsp_type r;
      r.status        = st;
      r.result_id     = rid;
      r.cancel_notify = note;
      r.notify_worker = wkr;
      return r;
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign better   = (rd_data_ff.state == ST_PENDING) && (rd_data_ff.prio > best_prio_ff);
   assign nb_prio  = better ? rd_data_ff.prio : best_prio_ff;
   assign nb_slot  = better ? rd_slot_ff : best_slot_ff;
   assign nb_found = found_ff || better;
   assign last     = (CNT_W'(rd_slot_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      best_prio_in = best_prio_ff;
      best_slot_in = best_slot_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      q_pop        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_status.empty && !rsp_valid_ff) begin
               q_pop = 1'b1;
               op_in = q_data;
               unique case (q_data.cmd)
                  CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (!q_data.prio_ok) begin
                        rsp_data_in = make_rsp(RS_BAD_PRIO, '0, 1'b0, '0);
                     end else if (count_ff == CNT_W'(TABLE_SIZE)) begin
                        rsp_data_in = make_rsp(RS_FULL, '0, 1'b0, '0);
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = IDX_W'(count_ff);
                        wr_data.prio  = q_data.priority_req;
                        wr_data.state = ST_PENDING;
                        wr_data.owner = '0;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_data_in   = make_rsp(RS_OK, ID_W'(count_ff) + ID_W'(1),
                                                 1'b0, '0);
                     end
                  end
                  CMD_ASSIGN: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = make_rsp(RS_NONE, '0, 1'b0, '0);
                     end else begin
                        rd_addr      = '0;
                        best_prio_in = '0;
                        best_slot_in = '0;
                        found_in     = 1'b0;
                        state_in     = S_SCAN;
                     end
                  end
                  CMD_COMPLETE, CMD_CANCEL: begin
                     if (q_data.id_zero || (q_data.task_id > ID_W'(count_ff))) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = make_rsp(RS_NOT_FOUND, '0, 1'b0, '0);
                     end else begin
                        rd_addr  = IDX_W'(q_data.task_id - ID_W'(1));
                        state_in = S_LOOKUP;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
            wr_addr       = rd_slot_ff;
            wr_data.prio  = rd_data_ff.prio;
            wr_data.owner = '0;
            if (op_ff.cmd == CMD_COMPLETE) begin
               wr_data.state = ST_COMPLETED;
               if ((rd_data_ff.state == ST_RUNNING) &&
                   (rd_data_ff.owner == op_ff.worker)) begin
                  wr_en       = 1'b1;
                  rsp_data_in = make_rsp(RS_OK, '0, 1'b0, '0);
               end else begin
                  rsp_data_in = make_rsp(RS_BAD_STATE, '0, 1'b0, '0);
               end
            end else begin
               wr_data.state = ST_CANCELLED;
               if ((rd_data_ff.state == ST_PENDING) || (rd_data_ff.state == ST_RUNNING)) begin
                  wr_en = 1'b1;
                  if ((rd_data_ff.state == ST_RUNNING) && (rd_data_ff.owner != '0)) begin
                     rsp_data_in = make_rsp(RS_OK, '0, 1'b1, rd_data_ff.owner);
                  end else begin
                     rsp_data_in = make_rsp(RS_OK, '0, 1'b0, '0);
                  end
               end else begin
                  rsp_data_in = make_rsp(RS_BAD_STATE, '0, 1'b0, '0);
               end
            end
         end
         S_SCAN: begin
            best_prio_in = nb_prio;
            best_slot_in = nb_slot;
            found_in     = nb_found;
            if (last) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (nb_found) begin
                  wr_en         = 1'b1;
                  wr_addr       = nb_slot;
                  wr_data.prio  = nb_prio;
                  wr_data.state = ST_RUNNING;
                  wr_data.owner = op_ff.worker;
                  rsp_data_in   = make_rsp(RS_OK, ID_W'(nb_slot) + ID_W'(1), 1'b0, '0);
               end else begin
                  rsp_data_in = make_rsp(RS_NONE, '0, 1'b0, '0);
               end
            end else begin
               rd_addr = rd_slot_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      best_prio_ff <= best_prio_in;
      best_slot_ff <= best_slot_in;
      found_ff     <= found_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
      rd_slot_ff <= rd_addr;
   end

endmodule

FILE: design/priority_task_table.sv
// Top level of the priority task table: front end, command queue and back end.
// Depends on ptt_pkg, ptt_front, ptt_queue, ptt_back and the assertion macros.
//
// Use: a command word enters on req_valid/req_ready (add, assign next, complete,
// cancel) and exactly one result word leaves on rsp_valid/rsp_ready for each,
// in order. The front registers and classifies the word, a two-word queue holds
// it until the back end, which owns the task entries, takes it.
// Path to rsp_valid: the front's stage register, then a queue slot, then the
// back end, which registers the result word at once for add and for any command
// answered without reading an entry, reads the entry first (state S_LOOKUP) for
// complete and cancel, and for assign next scans the tasks in the table (S_SCAN),
// reading one entry a cycle from the entry memory's single read port. The back
// end takes one word at a time and starts the next once the last result is taken.
// Reset empties the table and queue and drops any pending result; no clearing
// pass is needed. While rsp_ready is low the result word holds, the back end
// starts no new word, and the front keeps taking words until the queue and its
// own stage are full.
module priority_task_table import ptt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "priority_task_table_assert.svh"

   logic             q_push;
   op_type           q_push_data;
   logic             q_pop;
   op_type           q_pop_data;
   queue_status_type q_status;

   ptt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .q_full      (q_status.full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   ptt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   ptt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `PTT_ASSERT_NOW(a_pop_needs_free_out, clock, reset, q_pop, !rsp_valid, "pop while result held")
   `PTT_ASSERT_NOW(a_pop_needs_word, clock, reset, q_pop, !q_status.empty, "pop from empty queue")
   `PTT_ASSERT_NOW(a_fail_no_id, clock, reset, rsp_valid && (rsp_data.status != RS_OK), (rsp_data.result_id == '0) && !rsp_data.cancel_notify, "failed word carries id or notify")
   `PTT_ASSERT_NEXT(a_push_lands, clock, reset, q_push && !q_pop, !q_status.empty, "pushed word lost")

endmodule

FILE: test/ptt_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the priority task table: watches both channels, predicts
// each result word from its own copy of the table and compares. Needs ptt_pkg.
module ptt_result_checker import ptt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int unsigned mismatches,
   output int unsigned awaited,
   output int unsigned checked,
   output int unsigned notified
);

   logic [PRIO_W-1:0]   slot_prio  [TABLE_SIZE];
   entry_state_type     slot_state [TABLE_SIZE];
   logic [WORKER_W-1:0] slot_owner [TABLE_SIZE];
   int unsigned         slots_used;
   rsp_type             expected_results[$];
   int unsigned         fail_tally = 0;
   int unsigned         check_tally = 0;
   int unsigned         notify_tally = 0;

   function automatic rsp_type apply_command(req_type w);
      rsp_type             r;
      int                  pick;
      int                  slot;
      logic [PRIO_W-1:0]   best;
      r = '0;
      pick = -1;
      best = '0;
      slot = (w.task_id == 0 || w.task_id > slots_used) ? -1 : int'(w.task_id) - 1;
      case (w.cmd)
         CMD_ADD: begin
            if (w.priority_req < MIN_PRIORITY || w.priority_req > MAX_PRIORITY) begin
               r.status = RS_BAD_PRIO;
            end else if (slots_used >= TABLE_SIZE) begin
               r.status = RS_FULL;
            end else begin
               slot_prio[slots_used] = w.priority_req;
               slot_state[slots_used] = ST_PENDING;
               slot_owner[slots_used] = '0;
               slots_used++;
               r.result_id = ID_W'(slots_used);
            end
         end
         CMD_ASSIGN: begin
            for (int i = 0; i < slots_used; i++) begin
               if (slot_state[i] == ST_PENDING && slot_prio[i] > best) begin
                  best = slot_prio[i];
                  pick = i;
               end
            end
            if (pick < 0) begin
               r.status = RS_NONE;
            end else begin
               slot_state[pick] = ST_RUNNING;
               slot_owner[pick] = w.worker;
               r.result_id = ID_W'(pick + 1);
            end
         end
         CMD_COMPLETE: begin
            if (slot < 0) begin
               r.status = RS_NOT_FOUND;
            end else if (slot_state[slot] != ST_RUNNING || slot_owner[slot] != w.worker) begin
               r.status = RS_BAD_STATE;
            end else begin
               slot_state[slot] = ST_COMPLETED;
               slot_owner[slot] = '0;
            end
         end
         default: begin
            if (slot < 0) begin
               r.status = RS_NOT_FOUND;
            end else if (slot_state[slot] != ST_PENDING && slot_state[slot] != ST_RUNNING) begin
               r.status = RS_BAD_STATE;
            end else begin
               if (slot_state[slot] == ST_RUNNING && slot_owner[slot] != '0) begin
                  r.cancel_notify = 1'b1;
                  r.notify_worker = slot_owner[slot];
               end
               slot_state[slot] = ST_CANCELLED;
               slot_owner[slot] = '0;
            end
         end
      endcase
      return r;
   endfunction

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_tally++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         slots_used = 0;
         expected_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_command(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result word with nothing expected, status %0d id %0d",
                        $time, rsp_data.status, rsp_data.result_id);
               fail_tally++;
            end else begin
               want = expected_results.pop_front();
               compare_field("status", 8'(want.status), 8'(rsp_data.status));
               compare_field("result_id", want.result_id, rsp_data.result_id);
               compare_field("cancel_notify", 8'(want.cancel_notify), 8'(rsp_data.cancel_notify));
               compare_field("notify_worker", want.notify_worker, rsp_data.notify_worker);
               check_tally++;
               if (want.cancel_notify) begin
                  notify_tally++;
               end
            end
         end
      end
      mismatches <= fail_tally;
      awaited <= expected_results.size();
      checked <= check_tally;
      notified <= notify_tally;
   end

endmodule

FILE: test/tb_priority_task_table.sv
`timescale 1ns / 1ps
// Testbench top for the priority task table: drives directed and random command
// words with random idling on both sides, and gives the verdict.
// Needs ptt_pkg, the block and ptt_result_checker.
module tb_priority_task_table;
   import ptt_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_WORDS = 430;
   localparam int DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   int unsigned mismatches;
   int unsigned awaited;
   int unsigned checked;
   int unsigned notified;
   int unsigned adds_sent = 0;
   int unsigned words_sent = 0;
   int unsigned idle_cycles = 0;
   logic        quiet = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   priority_task_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ptt_result_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .awaited    (awaited),
      .checked    (checked),
      .notified   (notified)
   );

   function automatic req_type make_word(cmd_type c, int p, int id, int wk);
      req_type w;
      w.cmd = c;
      w.priority_req = PRIO_W'(p);
      w.task_id = ID_W'(id);
      w.worker = WORKER_W'(wk);
      return w;
   endfunction

   function automatic req_type random_word();
      req_type     w;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      w.priority_req = PRIO_W'($urandom);
      w.task_id = ID_W'($urandom);
      case ($urandom_range(0, 9))
         0: w.worker = '0;
         1: w.worker = WORKER_W'($urandom);
         default: w.worker = WORKER_W'($urandom_range(1, 3));
      endcase
      if (roll < 12) begin
         w.cmd = CMD_ADD;
         if ($urandom_range(0, 4) != 0) begin
            w.priority_req = PRIO_W'($urandom_range(MIN_PRIORITY, MAX_PRIORITY));
         end
      end else if (roll < 52) begin
         w.cmd = CMD_ASSIGN;
      end else begin
         if (roll < 85) begin
            w.cmd = CMD_COMPLETE;
         end else begin
            w.cmd = CMD_CANCEL;
         end
         if ($urandom_range(0, 6) != 0) begin
            w.task_id = ID_W'($urandom_range(1, adds_sent + 1));
         end
      end
      return w;
   endfunction

   // enter at a falling edge, leave at the falling edge after acceptance
   task automatic send_word(req_type w);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      words_sent++;
      if (w.cmd == CMD_ADD && w.priority_req >= MIN_PRIORITY &&
          w.priority_req <= MAX_PRIORITY && adds_sent < TABLE_SIZE) begin
         adds_sent++;
      end
      @(negedge clock);
   endtask

   initial begin
      int unsigned stall;
      @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(make_word(CMD_ASSIGN, 3, 0, 255));
      send_word(make_word(CMD_COMPLETE, 0, 0, 1));
      send_word(make_word(CMD_CANCEL, 0, 255, 1));
      send_word(make_word(CMD_ADD, 0, 0, 0));
      send_word(make_word(CMD_ADD, 6, 0, 0));
      send_word(make_word(CMD_ADD, 7, 255, 255));
      for (int p = 1; p <= 5; p++) begin
         send_word(make_word(CMD_ADD, p, 0, 0));
      end
      send_word(make_word(CMD_ADD, 5, 0, 0));
      send_word(make_word(CMD_ASSIGN, 0, 0, 255));
      send_word(make_word(CMD_ASSIGN, 0, 0, 0));
      send_word(make_word(CMD_ASSIGN, 0, 0, 1));
      send_word(make_word(CMD_COMPLETE, 0, 5, 1));
      send_word(make_word(CMD_COMPLETE, 0, 5, 255));
      send_word(make_word(CMD_COMPLETE, 0, 5, 255));
      send_word(make_word(CMD_COMPLETE, 0, 1, 1));
      send_word(make_word(CMD_CANCEL, 0, 6, 0));
      send_word(make_word(CMD_CANCEL, 0, 4, 1));
      send_word(make_word(CMD_CANCEL, 0, 1, 0));
      send_word(make_word(CMD_CANCEL, 0, 1, 0));
      send_word(make_word(CMD_COMPLETE, 0, 7, 1));

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         quiet = (i % 150) < 30;
         send_word(random_word());
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (awaited != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d command words and %0d checked results;", words_sent, checked);
      $display("%0d tasks entered the table, %0d cancels notified an owner.",
               adds_sent, notified);
      if (mismatches == 0 && awaited == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
